[src/swla_pkg.sv]
`default_nettype none

package swla_pkg;

    localparam int unsigned MAX_FRAME = 16;
    localparam logic [4:0]  HDR_BYTES = 5'd5;

    localparam logic [1:0] OP_SEND = 2'd0;
    localparam logic [1:0] OP_RECV = 2'd1;
    localparam logic [1:0] OP_TICK = 2'd2;
    localparam logic [1:0] OP_NONE = 2'd3;

    localparam logic [2:0] EV_NONE        = 3'd0;
    localparam logic [2:0] EV_BAD_VERSION = 3'd1;
    localparam logic [2:0] EV_PEER_READY  = 3'd2;
    localparam logic [2:0] EV_MOVE        = 3'd3;
    localparam logic [2:0] EV_REMATCH     = 3'd4;
    localparam logic [2:0] EV_LEAVE       = 3'd5;
    localparam logic [2:0] EV_LOST        = 3'd6;

    localparam logic [2:0] REG_MAGIC    = 3'd0;
    localparam logic [2:0] REG_VERSION  = 3'd1;
    localparam logic [2:0] REG_INTERVAL = 3'd2;
    localparam logic [2:0] REG_LIMIT    = 3'd3;
    localparam logic [2:0] REG_HELLO    = 3'd4;
    localparam logic [2:0] REG_MOVE     = 3'd5;
    localparam logic [2:0] REG_REMATCH  = 3'd6;
    localparam logic [2:0] REG_LEAVE    = 3'd7;

    typedef struct packed {
        logic [7:0]  magic;
        logic [7:0]  version;
        logic [15:0] interval;
        logic [3:0]  limit;
        logic [7:0]  code_hello;
        logic [7:0]  code_move;
        logic [7:0]  code_rematch;
        logic [7:0]  code_leave;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [7:0]  msg_type;
        logic [4:0]  item_len;
        logic [39:0] rx_header;
        logic [23:0] item_payload;
        logic [31:0] tick_ms;
    } item_t;

    typedef struct packed {
        logic [3:0]  tx_len;
        logic [39:0] tx_header;
        logic [23:0] tx_payload;
        logic [2:0]  event_kind;
        logic [7:0]  event_arg_a;
        logic [7:0]  event_arg_b;
        logic        link_busy;
    } result_t;

    // Payload bytes a type carries; earlier codes win where codes overlap.
    function automatic logic [1:0] expected_len(input cfg_t cfg, input logic [7:0] t);
        logic [1:0] n;
        priority if (t == cfg.code_hello) begin
            n = 2'd3;
        end else if (t == cfg.code_move) begin
            n = 2'd2;
        end else if (t == cfg.code_rematch) begin
            n = 2'd1;
        end else begin
            n = 2'd0;
        end
        return n;
    endfunction

endpackage

`default_nettype wire

[src/swla_cfg_regs.sv]
`default_nettype none

module swla_cfg_regs (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           cfg_valid,
    output logic                cfg_ready,
    input  wire logic [2:0]     cfg_index,
    input  wire logic [15:0]    cfg_data,
    output swla_pkg::cfg_t      cfg
);

    swla_pkg::cfg_t cfg_reg;
    swla_pkg::cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg      = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                swla_pkg::REG_MAGIC:    cfg_next.magic        = cfg_data[7:0];
                swla_pkg::REG_VERSION:  cfg_next.version      = cfg_data[7:0];
                swla_pkg::REG_INTERVAL: cfg_next.interval     = cfg_data;
                swla_pkg::REG_LIMIT:    cfg_next.limit        = cfg_data[3:0];
                swla_pkg::REG_HELLO:    cfg_next.code_hello   = cfg_data[7:0];
                swla_pkg::REG_MOVE:     cfg_next.code_move    = cfg_data[7:0];
                swla_pkg::REG_REMATCH:  cfg_next.code_rematch = cfg_data[7:0];
                swla_pkg::REG_LEAVE:    cfg_next.code_leave   = cfg_data[7:0];
                default:                cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.magic        <= 8'd170;
            cfg_reg.version      <= 8'd1;
            cfg_reg.interval     <= 16'd300;
            cfg_reg.limit        <= 4'd5;
            cfg_reg.code_hello   <= 8'd1;
            cfg_reg.code_move    <= 8'd2;
            cfg_reg.code_rematch <= 8'd3;
            cfg_reg.code_leave   <= 8'd4;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

[src/swla_engine.sv]
`default_nettype none

module swla_engine (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           advance,
    input  wire swla_pkg::cfg_t  cfg,
    input  wire swla_pkg::item_t item,
    output swla_pkg::result_t   result
);

    logic [39:0] pend_hdr_reg, pend_hdr_next;
    logic [23:0] pend_pay_reg, pend_pay_next;
    logic [3:0]  pend_len_reg, pend_len_next;
    logic [6:0]  pend_seq_reg, pend_seq_next;
    logic        pend_valid_reg, pend_valid_next;
    logic [3:0]  retry_reg, retry_next;
    logic [31:0] elapsed_reg, elapsed_next;
    logic [6:0]  next_seq_reg, next_seq_next;
    logic [6:0]  last_peer_reg, last_peer_next;
    logic        ack_owed_reg, ack_owed_next;
    logic        peer_seen_reg, peer_seen_next;

    logic [7:0]  rx_magic, rx_version, rx_type, rx_seqb, rx_ackb;
    logic [7:0]  pay0, pay1, pay2;
    logic [7:0]  ack_byte_old, ack_byte_new;
    logic [39:0] pure_ack_old;
    logic [1:0]  send_len, rx_exp;
    logic [23:0] send_mask;
    logic [32:0] elapsed_sum;
    logic [31:0] elapsed_sat;
    logic        recv_ok, dup, in_order;
    logic [6:0]  want_seq;

    assign rx_magic   = item.rx_header[7:0];
    assign rx_version = item.rx_header[15:8];
    assign rx_type    = item.rx_header[23:16];
    assign rx_seqb    = item.rx_header[31:24];
    assign rx_ackb    = item.rx_header[39:32];
    assign pay0       = item.item_payload[7:0];
    assign pay1       = item.item_payload[15:8];
    assign pay2       = item.item_payload[23:16];

    assign ack_byte_old = ack_owed_reg ? {1'b1, last_peer_reg} : 8'h00;
    assign ack_byte_new = {1'b1, rx_seqb[6:0]};
    assign pure_ack_old = {ack_byte_old, 16'h0000, cfg.version, cfg.magic};

    assign send_len = swla_pkg::expected_len(cfg, item.msg_type);
    assign rx_exp   = swla_pkg::expected_len(cfg, rx_type);

    always_comb begin
        unique case (send_len)
            2'd0: send_mask = 24'h000000;
            2'd1: send_mask = 24'h0000FF;
            2'd2: send_mask = 24'h00FFFF;
            2'd3: send_mask = 24'hFFFFFF;
            default: send_mask = 24'h000000;
        endcase
    end

    assign elapsed_sum = {1'b0, elapsed_reg} + {1'b0, item.tick_ms};
    assign elapsed_sat = elapsed_sum[32] ? 32'hFFFF_FFFF : elapsed_sum[31:0];

    assign want_seq = peer_seen_reg ? (last_peer_reg + 7'd1) : 7'd0;
    assign dup      = peer_seen_reg && (rx_seqb[6:0] == last_peer_reg);
    assign in_order = rx_seqb[6:0] == want_seq;

    always_comb begin
        pend_hdr_next   = pend_hdr_reg;
        pend_pay_next   = pend_pay_reg;
        pend_len_next   = pend_len_reg;
        pend_seq_next   = pend_seq_reg;
        pend_valid_next = pend_valid_reg;
        retry_next      = retry_reg;
        elapsed_next    = elapsed_reg;
        next_seq_next   = next_seq_reg;
        last_peer_next  = last_peer_reg;
        ack_owed_next   = ack_owed_reg;
        peer_seen_next  = peer_seen_reg;
        recv_ok         = 1'b0;

        result.tx_len      = 4'd0;
        result.tx_header   = 40'd0;
        result.tx_payload  = 24'd0;
        result.event_kind  = swla_pkg::EV_NONE;
        result.event_arg_a = 8'd0;
        result.event_arg_b = 8'd0;

        unique case (item.opcode)
            swla_pkg::OP_SEND: begin
                if (item.item_len == {3'b000, send_len}) begin
                    result.tx_header  = {ack_byte_old, 1'b1, next_seq_reg, item.msg_type,
                                         cfg.version, cfg.magic};
                    result.tx_payload = item.item_payload & send_mask;
                    result.tx_len     = 4'd5 + {2'b00, send_len};
                    pend_hdr_next     = result.tx_header;
                    pend_pay_next     = result.tx_payload;
                    pend_len_next     = result.tx_len;
                    pend_seq_next     = next_seq_reg;
                    retry_next        = 4'd0;
                    elapsed_next      = 32'd0;
                    pend_valid_next   = 1'b1;
                    next_seq_next     = next_seq_reg + 7'd1;
                end
            end
            swla_pkg::OP_RECV: begin
                if (item.item_len >= swla_pkg::HDR_BYTES
                        && item.item_len <= 5'(swla_pkg::MAX_FRAME)
                        && rx_magic == cfg.magic) begin
                    if (rx_version != cfg.version) begin
                        result.event_kind  = swla_pkg::EV_BAD_VERSION;
                        result.event_arg_a = rx_version;
                        result.tx_header   = pure_ack_old;
                        result.tx_len      = 4'd5;
                    end else begin
                        // Piggybacked ack retires the pending frame.
                        if (rx_ackb[7] && pend_valid_reg && rx_ackb[6:0] == pend_seq_reg) begin
                            pend_valid_next = 1'b0;
                            retry_next      = 4'd0;
                        end
                        recv_ok = rx_seqb[7];
                        if (recv_ok && rx_type == cfg.code_hello) begin
                            if (item.item_len != 5'd8) begin
                                recv_ok = 1'b0;
                            end else if (pay0 != cfg.version) begin
                                result.event_kind  = swla_pkg::EV_BAD_VERSION;
                                result.event_arg_a = pay0;
                                result.tx_header   = pure_ack_old;
                                result.tx_len      = 4'd5;
                                recv_ok            = 1'b0;
                            end
                        end else if (recv_ok
                                && {3'b000, rx_exp} != item.item_len - swla_pkg::HDR_BYTES) begin
                            recv_ok = 1'b0;
                        end
                        if (recv_ok) begin
                            if (dup) begin
                                // Resend the ack for a repeated frame.
                                result.tx_header = pure_ack_old;
                                result.tx_len    = 4'd5;
                            end else if (in_order) begin
                                last_peer_next   = rx_seqb[6:0];
                                ack_owed_next    = 1'b1;
                                peer_seen_next   = 1'b1;
                                result.tx_header = {ack_byte_new, 16'h0000, cfg.version,
                                                    cfg.magic};
                                result.tx_len    = 4'd5;
                                priority if (rx_type == cfg.code_hello) begin
                                    result.event_kind  = swla_pkg::EV_PEER_READY;
                                    result.event_arg_a = pay1;
                                    result.event_arg_b = pay2;
                                end else if (rx_type == cfg.code_move) begin
                                    result.event_kind  = swla_pkg::EV_MOVE;
                                    result.event_arg_a = pay0;
                                    result.event_arg_b = pay1;
                                end else if (rx_type == cfg.code_rematch) begin
                                    result.event_kind  = swla_pkg::EV_REMATCH;
                                    result.event_arg_a = pay0;
                                end else if (rx_type == cfg.code_leave) begin
                                    result.event_kind  = swla_pkg::EV_LEAVE;
                                end else begin
                                    result.event_kind  = swla_pkg::EV_NONE;
                                end
                            end
                        end
                    end
                end
            end
            swla_pkg::OP_TICK: begin
                if (pend_valid_reg) begin
                    elapsed_next = elapsed_sat;
                    if (elapsed_sat >= {16'h0000, cfg.interval}) begin
                        if (retry_reg >= cfg.limit) begin
                            pend_valid_next   = 1'b0;
                            retry_next        = 4'd0;
                            result.event_kind = swla_pkg::EV_LOST;
                        end else begin
                            result.tx_header  = pend_hdr_reg;
                            result.tx_payload = pend_pay_reg;
                            result.tx_len     = pend_len_reg;
                            retry_next        = retry_reg + 4'd1;
                            elapsed_next      = 32'd0;
                        end
                    end
                end
            end
            swla_pkg::OP_NONE: begin
                recv_ok = 1'b0;
            end
            default: begin
                recv_ok = 1'b0;
            end
        endcase

        result.link_busy = pend_valid_next;
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            pend_hdr_reg <= pend_hdr_next;
            pend_pay_reg <= pend_pay_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_len_reg   <= 4'd0;
            pend_seq_reg   <= 7'd0;
            pend_valid_reg <= 1'b0;
            retry_reg      <= 4'd0;
            elapsed_reg    <= 32'd0;
            next_seq_reg   <= 7'd0;
            last_peer_reg  <= 7'd0;
            ack_owed_reg   <= 1'b0;
            peer_seen_reg  <= 1'b0;
        end else if (advance) begin
            pend_len_reg   <= pend_len_next;
            pend_seq_reg   <= pend_seq_next;
            pend_valid_reg <= pend_valid_next;
            retry_reg      <= retry_next;
            elapsed_reg    <= elapsed_next;
            next_seq_reg   <= next_seq_next;
            last_peer_reg  <= last_peer_next;
            ack_owed_reg   <= ack_owed_next;
            peer_seen_reg  <= peer_seen_next;
        end
    end

endmodule

`default_nettype wire

[src/stop_and_wait_link_arq.sv]
// An accepted request is held in the input register; its result is then registered for output.
// Throughput: one request per cycle while m_ready is high; the input and result registers
// each refill in the cycle they empty, so back-to-back requests flow at full rate.
// Reset (aresetn low, synchronous): both registers empty, link state cleared,
// configuration registers return to their defaults.
`default_nettype none

module stop_and_wait_link_arq (
    input  wire logic           aclk,
    input  wire logic           aresetn,

    input  wire logic           cfg_valid,
    output logic                cfg_ready,
    input  wire logic [2:0]     cfg_index,
    input  wire logic [15:0]    cfg_data,

    input  wire logic           s_valid,
    output logic                s_ready,
    input  wire logic [1:0]     s_opcode,
    input  wire logic [7:0]     s_msg_type,
    input  wire logic [4:0]     s_item_len,
    input  wire logic [39:0]    s_rx_header,
    input  wire logic [23:0]    s_item_payload,
    input  wire logic [31:0]    s_tick_ms,

    output logic                m_valid,
    input  wire logic           m_ready,
    output logic [3:0]          m_tx_len,
    output logic [39:0]         m_tx_header,
    output logic [23:0]         m_tx_payload,
    output logic [2:0]          m_event_kind,
    output logic [7:0]          m_event_arg_a,
    output logic [7:0]          m_event_arg_b,
    output logic                m_link_busy
);

    swla_pkg::cfg_t    cfg;
    swla_pkg::item_t   item_reg;
    swla_pkg::result_t result_next;
    swla_pkg::result_t result_reg;
    logic              in_valid_reg;
    logic              out_valid_reg;
    logic              advance;

    swla_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Move the held request into the result register when that register frees up.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg.opcode       <= s_opcode;
            item_reg.msg_type     <= s_msg_type;
            item_reg.item_len     <= s_item_len;
            item_reg.rx_header    <= s_rx_header;
            item_reg.item_payload <= s_item_payload;
            item_reg.tick_ms      <= s_tick_ms;
        end
    end

    swla_engine u_engine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .cfg     (cfg),
        .item    (item_reg),
        .result  (result_next)
    );

    always_ff @(posedge aclk) begin
        if (advance) begin
            result_reg <= result_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_tx_len      = result_reg.tx_len;
    assign m_tx_header   = result_reg.tx_header;
    assign m_tx_payload  = result_reg.tx_payload;
    assign m_event_kind  = result_reg.event_kind;
    assign m_event_arg_a = result_reg.event_arg_a;
    assign m_event_arg_b = result_reg.event_arg_b;
    assign m_link_busy   = result_reg.link_busy;

endmodule

`default_nettype wire
